/* hw/rtl/earom_pkg.sv */
// Shared types, codes and constants of the EAROM controller.
`timescale 1ns / 1ps

package earom_pkg;

   localparam int CELLS_DEFAULT = 64;
   localparam int ADDR_W        = 6;
   localparam int DATA_W        = 8;
   localparam int CTRL_W        = 5;

   // Request type codes.
   localparam logic [1:0] REQ_LATCH = 2'd0;
   localparam logic [1:0] REQ_CTRL  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Bit positions in the control register.
   localparam int CB_CK  = 0;
   localparam int CB_C1  = 1;
   localparam int CB_C2  = 2;
   localparam int CB_CS1 = 3;
   localparam int CB_CS2 = 4;

   localparam logic [DATA_W-1:0] ERASED = 8'hff;

   typedef struct packed {
      logic clear_step;
      logic latch_load;
      logic ctrl_load;
      logic mem_erase;
      logic mem_and;
      logic latch_from_mem;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op_read;
      logic op_rmw;
      logic op_erase;
   } stat_type;

endpackage

/* hw/rtl/earom_controller_unit.sv */
// Top level of the EAROM controller: controller and datapath joined.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_type, req_addr, req_value
//   rsp       out        rsp_valid/rsp_stall   rsp_read_data
//
// After reset a clearing pass writes 0xFF to every cell, with req stalled.
// Latch, data read, mode-only control words and erases are answered from the idle state;
// a control word that reads a cell or does a write (read, AND, write back) goes on to a
// READ or RMW state, needed by the registered read port of the cell store.
// One word is worked at a time; a result held by rsp_stall stalls req, and the next
// word is taken no earlier than the cycle in which the waiting result leaves.
`timescale 1ns / 1ps

module earom_controller_unit #(
   parameter int CELLS = earom_pkg::CELLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [earom_pkg::ADDR_W-1:0]  req_addr,
   input  logic [earom_pkg::DATA_W-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [earom_pkg::DATA_W-1:0]  rsp_read_data
);

   earom_pkg::cmd_type  cmd;
   earom_pkg::stat_type stat;

   earom_sequencer u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   earom_datapath #(
      .CELLS (CELLS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_addr      (req_addr),
      .req_value     (req_value),
      .rsp_read_data (rsp_read_data)
   );

endmodule

/* hw/rtl/earom_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module earom_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/earom_datapath.sv */
// Datapath: latches, control register, control decode and the cell store.
`timescale 1ns / 1ps

module earom_datapath #(
   parameter int CELLS = earom_pkg::CELLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  earom_pkg::cmd_type               cmd,
   output earom_pkg::stat_type              stat,
   input  logic [earom_pkg::ADDR_W-1:0]     req_addr,
   input  logic [earom_pkg::DATA_W-1:0]     req_value,
   output logic [earom_pkg::DATA_W-1:0]     rsp_read_data
);

   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MOD_W = IDX_W + 7;

   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [IDX_W-1:0]               clr_ff, clr_in;
   logic [earom_pkg::DATA_W-1:0]   data_latch_ff, data_latch_in;
   logic [earom_pkg::CTRL_W-1:0]   ctrl_ff, ctrl_in;
   logic [earom_pkg::DATA_W-1:0]   read_data_ff, read_data_in;
   logic [earom_pkg::CTRL_W-1:0]   ctrl_mid;
   logic                           sel, fall, changed, act, c1, c2;
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [earom_pkg::DATA_W-1:0]   wr_data;
   logic [earom_pkg::DATA_W-1:0]   rd_data;

   // Address modulo the store depth by restoring compare and subtract.
   function automatic logic [IDX_W-1:0] cell_of(input logic [earom_pkg::ADDR_W-1:0] a);
      logic [MOD_W-1:0] r;
      r = MOD_W'(a);
      for (int k = earom_pkg::ADDR_W - 1; k >= 0; k--) begin
         if (r >= (MOD_W'(CELLS) << k)) begin
            r = r - (MOD_W'(CELLS) << k);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   // Control byte decode; the clock bit keeps its old value for the mode step.
   always_comb begin
      ctrl_mid = '0;
      ctrl_mid[earom_pkg::CB_CK]  = ctrl_ff[earom_pkg::CB_CK];
      ctrl_mid[earom_pkg::CB_C1]  = ~req_value[2];
      ctrl_mid[earom_pkg::CB_C2]  = req_value[1];
      ctrl_mid[earom_pkg::CB_CS1] = req_value[3];
      ctrl_mid[earom_pkg::CB_CS2] = 1'b1;
      sel     = req_value[3];
      c1      = ~req_value[2];
      c2      = req_value[1];
      changed = (ctrl_mid != ctrl_ff);
      fall    = ctrl_ff[earom_pkg::CB_CK] & ~req_value[0];
      // Acting twice on the same cell gives the same result as acting once.
      act     = sel & (changed | fall);
      stat.op_read  = sel & fall & c1;
      stat.op_rmw   = act & ~c1 & ~c2;
      stat.op_erase = act & ~c1 & c2;
      stat.clear_done = (clr_ff == IDX_W'(CELLS - 1));
   end

   always_comb begin
      idx_in        = idx_ff;
      data_latch_in = data_latch_ff;
      ctrl_in       = ctrl_ff;
      clr_in        = clr_ff;
      read_data_in  = read_data_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (cmd.latch_load) begin
         idx_in        = cell_of(req_addr);
         data_latch_in = req_value;
      end
      if (cmd.latch_from_mem) begin
         data_latch_in = rd_data;
      end
      if (cmd.ctrl_load) begin
         ctrl_in = {ctrl_mid[earom_pkg::CTRL_W-1:1], req_value[0]};
      end
      if (cmd.rsp_load) begin
         read_data_in = data_latch_in;
      end
   end

   always_comb begin
      wr_en   = cmd.clear_step | cmd.mem_erase | cmd.mem_and;
      wr_addr = cmd.clear_step ? clr_ff : idx_ff;
      wr_data = cmd.mem_and ? (rd_data & data_latch_ff) : earom_pkg::ERASED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         clr_ff        <= '0;
         data_latch_ff <= '0;
         ctrl_ff       <= '0;
      end else begin
         idx_ff        <= idx_in;
         clr_ff        <= clr_in;
         data_latch_ff <= data_latch_in;
         ctrl_ff       <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
   end

   earom_ram #(
      .WIDTH (earom_pkg::DATA_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_read_data = read_data_ff;

endmodule

/* hw/rtl/earom_ctrl.sv */
// Controller state machine: clearing pass, access sequencing and output word.
`timescale 1ns / 1ps

module earom_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output earom_pkg::cmd_type   cmd,
   input  earom_pkg::stat_type  stat
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_RMW   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  earom_pkg::REQ_LATCH: begin
                     cmd.latch_load = 1'b1;
                     cmd.rsp_load   = 1'b1;
                  end
                  earom_pkg::REQ_CTRL: begin
                     cmd.ctrl_load = 1'b1;
                     if (stat.op_read) begin
                        state_in = ST_READ;
                     end else if (stat.op_rmw) begin
                        state_in = ST_RMW;
                     end else begin
                        cmd.mem_erase = stat.op_erase;
                        cmd.rsp_load  = 1'b1;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.latch_from_mem = 1'b1;
            cmd.rsp_load       = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_RMW: begin
            cmd.mem_and  = 1'b1;
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   // The output word is free whenever a new access is taken, so a load never overwrites.
   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
